// ===== design/pec_pkg.sv =====
// ----------------------------------------------------------------------------
// pec_pkg: shared constants and types for the polynomial easing curve core
// Widths, pipeline stage map, register indexes, status codes, stage payloads.
// ----------------------------------------------------------------------------
package pec_pkg;

  localparam int POS_W      = 16;
  localparam int FRAC_W     = 32;
  localparam int T_W        = FRAC_W + 1;
  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = FRAC_W / DIV_STEP;
  localparam int POW_MULS   = 4;
  localparam int CNT_W      = 3;
  localparam int MODE_W     = 4;
  localparam int VAL_W      = 31;
  localparam int OUT_W      = 32;
  localparam int CFG_W      = 31;
  localparam int PROD_W     = 2 * T_W;
  localparam int QPROD_W    = VAL_W + T_W;

  localparam int ST_POW0 = DIV_STAGES + 1;
  localparam int ST_F    = ST_POW0 + POW_MULS + 1;
  localparam int ST_PROD = ST_F + 1;
  localparam int ST_OUT  = ST_PROD + 1;
  localparam int NSTG    = ST_OUT + 1;

  localparam logic [T_W-1:0] FRAC_ONE = T_W'(1) << FRAC_W;

  typedef enum logic [1:0] {
    CFG_MODE     = 2'd0,
    CFG_START    = 2'd1,
    CFG_CHANGE   = 2'd2,
    CFG_DURATION = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_DUR_ZERO = 2'd1,
    STAT_CLAMPED  = 2'd2
  } status_e;

  typedef struct packed {
    logic [POS_W-1:0] rem;
    logic [T_W-1:0]   t;
    status_e          status;
  } div_t;

  typedef struct packed {
    logic [T_W-1:0]   b;
    logic [T_W-1:0]   p;
    logic [CNT_W-1:0] cnt;
    status_e          status;
  } pow_t;

  typedef struct packed {
    logic [T_W-1:0] f;
    status_e        status;
  } frac_t;

  typedef struct packed {
    logic [OUT_W-1:0] q;
    logic             inexact;
    status_e          status;
  } scl_t;

endpackage

// ===== design/polynomial_easing_curve_core.sv =====
// ----------------------------------------------------------------------------
// polynomial_easing_curve_core
// Streams positions through a fixed-point easing curve: t = pos/dur, power
// curve in or out form, then start + change * f(t), floored.
// ----------------------------------------------------------------------------
// channel  | direction | handshake               | payload
// ---------+-----------+-------------------------+--------------------------
// in       | sink      | in_valid_i / in_stall_o | position_i
// out      | source    | out_valid_o/out_stall_i | curve_value_o, status_o
// cfg      | sink      | cfg_we_i                | cfg_index_i, cfg_data_i
//
// Seventeen register stages: one setup stage, eight divider stages (four
// quotient bits each), a base stage, four multiply stages, curve select,
// scaling multiply and output register. One beat per cycle unless stalled.
// A full stage holds while the next is full and held, so bubbles collapse.
// Reset empties the pipeline and loads the register defaults.
// ----------------------------------------------------------------------------
module polynomial_easing_curve_core import pec_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [POS_W-1:0]        position_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [OUT_W-1:0] curve_value_o,
  output logic [1:0]              status_o,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_index_i,
  input  logic [CFG_W-1:0]        cfg_data_i
);

  logic signed [MODE_W-1:0] mode_q;
  logic signed [VAL_W-1:0]  start_q;
  logic signed [VAL_W-1:0]  change_q;
  logic [POS_W-1:0]         dur_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= '0;
      start_q  <= '0;
      change_q <= '0;
      dur_q    <= POS_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MODE:     mode_q   <= cfg_data_i[MODE_W-1:0];
        CFG_START:    start_q  <= cfg_data_i[VAL_W-1:0];
        CFG_CHANGE:   change_q <= cfg_data_i[VAL_W-1:0];
        CFG_DURATION: dur_q    <= cfg_data_i[POS_W-1:0];
        default: ;
      endcase
    end
  end

  logic                   known;
  logic [MODE_W-1:0]      mode_abs;
  logic                   out_form;
  assign known    = (mode_q >= -4) && (mode_q <= 4);
  assign mode_abs = mode_q[MODE_W-1] ? MODE_W'(-mode_q) : MODE_W'(mode_q);
  assign out_form = (mode_q > 0);

  // stage enables: a stage loads when empty or when its contents move on
  logic [NSTG-1:0] v_q;
  logic [NSTG-1:0] en;

  always_comb begin
    en[NSTG-1] = !v_q[NSTG-1] || !out_stall_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (en[k]) begin
          v_q[k] <= (k == 0) ? in_valid_i : v_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  // setup: clamp, status, first quotient bit
  div_t div_q [0:DIV_STAGES];
  div_t div0_d;
  logic [POS_W-1:0] pos_c;

  always_comb begin
    pos_c = (position_i > dur_q) ? dur_q : position_i;
    if (dur_q == '0) begin
      div0_d.status = STAT_DUR_ZERO;
    end else if (position_i > dur_q) begin
      div0_d.status = STAT_CLAMPED;
    end else begin
      div0_d.status = STAT_OK;
    end
    div0_d.t   = T_W'(pos_c >= dur_q);
    div0_d.rem = (pos_c >= dur_q) ? pos_c - dur_q : pos_c;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      div_q[0] <= div0_d;
    end
  end

  // restoring divider, DIV_STEP quotient bits per stage
  for (genvar g = 1; g <= DIV_STAGES; g++) begin : g_div
    div_t div_d;
    always_comb begin
      logic [POS_W:0] r2;
      div_d = div_q[g-1];
      for (int j = 0; j < DIV_STEP; j++) begin
        r2 = {div_d.rem, 1'b0};
        if (r2 >= {1'b0, dur_q}) begin
          r2        = r2 - {1'b0, dur_q};
          div_d.t   = {div_d.t[T_W-2:0], 1'b1};
        end else begin
          div_d.t   = {div_d.t[T_W-2:0], 1'b0};
        end
        div_d.rem = r2[POS_W-1:0];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en[g]) begin
        div_q[g] <= div_d;
      end
    end
  end

  // base: t for in forms, 1 - t for out forms
  pow_t pow_q [0:POW_MULS];
  pow_t pow0_d;

  always_comb begin
    pow0_d.b      = out_form ? FRAC_ONE - div_q[DIV_STAGES].t : div_q[DIV_STAGES].t;
    pow0_d.p      = pow0_d.b;
    pow0_d.cnt    = known ? mode_abs[CNT_W-1:0] : '0;
    pow0_d.status = div_q[DIV_STAGES].status;
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_POW0]) begin
      pow_q[0] <= pow0_d;
    end
  end

  for (genvar g = 1; g <= POW_MULS; g++) begin : g_pow
    pow_t             pow_d;
    logic [PROD_W-1:0] prod;
    assign prod = pow_q[g-1].p * pow_q[g-1].b;
    always_comb begin
      pow_d = pow_q[g-1];
      if (pow_q[g-1].cnt != '0) begin
        pow_d.p   = prod[FRAC_W +: T_W];
        pow_d.cnt = pow_q[g-1].cnt - CNT_W'(1);
      end
    end
    always_ff @(posedge clk_i) begin
      if (en[ST_POW0 + g]) begin
        pow_q[g] <= pow_d;
      end
    end
  end

  // curve select
  frac_t f_q;
  always_ff @(posedge clk_i) begin
    if (en[ST_F]) begin
      f_q.f      <= out_form ? FRAC_ONE - pow_q[POW_MULS].p : pow_q[POW_MULS].p;
      f_q.status <= pow_q[POW_MULS].status;
    end
  end

  // scale by |change|
  scl_t              scl_q;
  logic [VAL_W-1:0]  mag;
  logic [QPROD_W-1:0] qprod;
  assign mag   = change_q[VAL_W-1] ? VAL_W'(-change_q) : VAL_W'(change_q);
  assign qprod = mag * f_q.f;

  always_ff @(posedge clk_i) begin
    if (en[ST_PROD]) begin
      scl_q.q       <= qprod[FRAC_W +: OUT_W];
      scl_q.inexact <= |qprod[FRAC_W-1:0];
      scl_q.status  <= f_q.status;
    end
  end

  // floor and add start
  logic signed [OUT_W-1:0] start_x;
  logic signed [OUT_W-1:0] delta;
  logic signed [OUT_W-1:0] value_d;
  logic signed [OUT_W-1:0] value_q;
  status_e                 status_q;

  assign start_x = OUT_W'(start_q);

  always_comb begin
    if (change_q[VAL_W-1]) begin
      delta = -$signed(scl_q.q) - $signed(OUT_W'(scl_q.inexact));
    end else begin
      delta = $signed(scl_q.q);
    end
    if (!known) begin
      value_d = '0;
    end else if (scl_q.status == STAT_DUR_ZERO) begin
      value_d = start_x;
    end else begin
      value_d = start_x + delta;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) begin
      value_q  <= value_d;
      status_q <= scl_q.status;
    end
  end

  assign out_valid_o   = v_q[ST_OUT];
  assign curve_value_o = value_q;
  assign status_o      = status_q;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Polynomial easing curve core testbench
// Streams positions through the core under several register settings and
// compares every output beat against an in-bench fixed-point curve predictor.
// ----------------------------------------------------------------------------
module tb;
  import pec_pkg::*;

  localparam int LATENCY = 17;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [POS_W-1:0]        position_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [OUT_W-1:0] curve_value_o;
  logic [1:0]              status_o;
  logic                    cfg_we_i = 1'b0;
  logic [1:0]              cfg_index_i = CFG_MODE;
  logic [CFG_W-1:0]        cfg_data_i = '0;

  typedef struct {
    logic [31:0] value;
    logic [1:0]  status;
  } curve_beat_t;

  curve_beat_t   curve_q[$];
  int            error_count = 0;
  bit            idle_enable = 1'b1;
  int            hold_off = 0;
  int            stall_left = 0;

  // predictor copy of the registers
  logic signed [3:0]  mode_r;
  logic signed [30:0] start_r;
  logic signed [30:0] change_r;
  logic [15:0]        dur_r;

  polynomial_easing_curve_core dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("tb: errors");
    $finish;
  end

  // floor(a*b / 2^32)
  function automatic logic [63:0] frac_mul(logic [63:0] a, logic [63:0] b, output bit inexact);
    logic [127:0] p;
    p = a * b;
    inexact = p[31:0] != 0;
    return p[95:32];
  endfunction

  function automatic logic [63:0] frac_pow(logic [63:0] base, int n);
    logic [63:0] p;
    bit          dummy;
    p = base;
    for (int i = 1; i < n; i++) p = frac_mul(p, base, dummy);
    return p;
  endfunction

  function automatic curve_beat_t predict_curve(logic [15:0] pos_in);
    curve_beat_t r;
    logic [63:0] pos, t, f, mag, q;
    bit          known, inexact;
    int          n;
    logic signed [63:0] delta, value;
    pos = pos_in;
    known = mode_r >= -4 && mode_r <= 4;
    r.status = STAT_OK;
    if (dur_r == 0) begin
      r.status = STAT_DUR_ZERO;
      value = known ? 64'(start_r) : 0;
    end else begin
      if (pos > dur_r) begin
        pos = dur_r;
        r.status = STAT_CLAMPED;
      end
      t = (pos << 32) / dur_r;
      n = (mode_r < 0 ? -int'(mode_r) : int'(mode_r)) + 1;
      if (mode_r == 0) f = t;
      else if (mode_r < 0) f = frac_pow(t, n);
      else f = (64'd1 << 32) - frac_pow((64'd1 << 32) - t, n);
      mag = change_r < 0 ? 64'(-64'(change_r)) : 64'(change_r);
      q = frac_mul(mag, f, inexact);
      if (change_r < 0) delta = -$signed(q) - (inexact ? 1 : 0);
      else delta = $signed(q);
      value = known ? 64'(start_r) + delta : 0;
    end
    r.value = value[31:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    error_count++;
  endtask

  // check each output beat
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (curve_q.size() == 0) begin
        report_mismatch("unexpected beat", curve_value_o, 0);
      end else begin
        curve_beat_t e;
        e = curve_q.pop_front();
        if (curve_value_o !== e.value) report_mismatch("curve_value", curve_value_o, e.value);
        if (status_o !== e.status) report_mismatch("status", status_o, e.status);
      end
    end
  end

  // receiver stall: random bursts, or a long counted hold-off
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (idle_enable && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 11);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_MODE:     mode_r = data[3:0];
      CFG_START:    start_r = data[30:0];
      CFG_CHANGE:   change_r = data[30:0];
      CFG_DURATION: dur_r = data[15:0];
      default: ;
    endcase
  endtask

  task automatic drain_results();
    while (curve_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_curve(int mode, int start, int change, int dur);
    drain_results();
    write_reg(CFG_MODE, CFG_W'(mode));
    write_reg(CFG_START, CFG_W'(start));
    write_reg(CFG_CHANGE, CFG_W'(change));
    write_reg(CFG_DURATION, CFG_W'(dur));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // offer one beat, with an optional random gap first
  task automatic send_position(logic [15:0] pos);
    if (idle_enable && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    position_i <= pos;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    curve_q.push_back(predict_curve(pos));
  endtask

  task automatic idle_input();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_pos();
    case ($urandom_range(0, 4))
      0: return dur_r;
      1: return $urandom_range(0, 3);
      2: return 16'hFFFF;
      default: return dur_r == 0 ? 16'($urandom) : 16'($urandom_range(0, dur_r + 2));
    endcase
  endfunction

  task automatic test_directed();
    int modes[10] = '{0, -1, -2, -3, -4, 1, 2, 3, 4, 0};
    set_curve(0, 100, 1000, 10);
    for (int m = 0; m < 9; m++) begin
      set_curve(modes[m], -1073741824, 1073741823, 7);
      send_position(0);
      send_position(3);
      idle_input();
    end
    set_curve(2, 1073741823, -1073741824, 65535);
    send_position(65535);
    send_position(32768);
    send_position(1);
    idle_input();
    set_curve(-3, 5, -3, 0);   // duration zero
    send_position(1234);
    idle_input();
    set_curve(-8, 5, 9, 0);    // unknown mode, duration zero
    send_position(0);
    idle_input();
    set_curve(7, 5, 9, 100);   // unknown mode, clamped
    send_position(200);
    send_position(50);
    idle_input();
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 80 == 0) begin
        idle_input();
        set_curve($urandom_range(0, 15) - 8 < -4 && $urandom_range(0, 3) != 0 ?
                    $urandom_range(0, 8) - 4 : $urandom_range(0, 15) - 8,
                  $urandom_range(0, 32'h7FFF_FFFF) - 1073741824,
                  $urandom_range(0, 32'h7FFF_FFFF) - 1073741824,
                  $urandom_range(0, 9) == 0 ? 0 :
                  $urandom_range(0, 3) == 0 ? $urandom_range(1, 65535) :
                  $urandom_range(1, 40));
      end
      send_position(rand_pos());
    end
    idle_input();
  endtask

  // block the output long enough for the pipeline to back up into its input
  task automatic test_backpressure();
    set_curve(-1, 0, 1000000, 300);
    hold_off = 60;
    for (int i = 0; i < 40; i++) send_position(16'($urandom_range(0, 320)));
    idle_input();
    drain_results();
  endtask

  task automatic test_streaming();
    idle_enable = 1'b0;
    set_curve(4, 12345, -987654, 1000);
    for (int i = 0; i < 100; i++) send_position(16'($urandom_range(0, 1100)));
    idle_input();
  endtask

  initial begin
    mode_r = 0;
    start_r = 0;
    change_r = 0;
    dur_r = 1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(600);
    test_backpressure();
    test_streaming();
    drain_results();
    repeat (LATENCY + 10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
